// File: rtl/jbt_pkg.sv
package jbt_pkg;

    // Result queue sizing: two results may enter per word, one leaves per cycle unless stalled.
    localparam int Q_DEPTH = 4;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam int Q_IDX_W = $clog2(Q_DEPTH);

    // Event codes.
    localparam logic [1:0] EV_CONTENT = 2'd0;
    localparam logic [1:0] EV_DONE    = 2'd1;
    localparam logic [1:0] EV_ERROR   = 2'd2;

    // Token kinds.
    localparam logic [3:0] KIND_LBRACK = 4'd0;
    localparam logic [3:0] KIND_RBRACK = 4'd1;
    localparam logic [3:0] KIND_LBRACE = 4'd2;
    localparam logic [3:0] KIND_RBRACE = 4'd3;
    localparam logic [3:0] KIND_COLON  = 4'd4;
    localparam logic [3:0] KIND_COMMA  = 4'd5;
    localparam logic [3:0] KIND_STRING = 4'd6;
    localparam logic [3:0] KIND_INT    = 4'd7;
    localparam logic [3:0] KIND_FLOAT  = 4'd8;
    localparam logic [3:0] KIND_BOOL   = 4'd9;
    localparam logic [3:0] KIND_NULL   = 4'd10;

    // Error codes.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_MINUS    = 3'd1;
    localparam logic [2:0] ERR_NUMBER   = 3'd2;
    localparam logic [2:0] ERR_STRING   = 3'd3;
    localparam logic [2:0] ERR_BOOL     = 3'd4;
    localparam logic [2:0] ERR_NULL     = 3'd5;

    // Character codes.
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_MINUS  = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_STRING = 3'd3,
        MODE_BOOL   = 3'd4,
        MODE_NULL   = 3'd5
    } t_mode;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } t_item;

    typedef struct packed {
        logic [1:0] event_res;
        logic [3:0] token_kind;
        logic [7:0] data_byte_out;
        logic [2:0] error_code;
        logic       last;
    } t_result;

    typedef struct packed {
        t_mode      mode;
        logic       bs_odd;
        logic [2:0] lit_pos;
        logic       lit_false;
        logic       lit_mis;
        logic [1:0] int_cnt;
        logic       lead_zero;
        logic [1:0] dot_cnt;
        logic [1:0] frac_len;
    } t_lex_state;

    typedef struct packed {
        logic idle;
    } t_lex_status;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               room;
    } t_q_status;

    function automatic t_result mk_res(input logic [1:0] ev, input logic [3:0] kind,
                                       input logic [7:0] data, input logic [2:0] err);
        t_result r;
        r.event_res     = ev;
        r.token_kind    = kind;
        r.data_byte_out = data;
        r.error_code    = err;
        r.last          = 1'b0;
        return r;
    endfunction

    // Expected character of "true" or "false" at a given position.
    function automatic logic [7:0] bool_char(input logic is_false, input logic [2:0] pos);
        logic [7:0] ch;
        ch = CH_NUL;
        if (is_false) begin
            case (pos)
                3'd0:    ch = CH_F;
                3'd1:    ch = CH_A;
                3'd2:    ch = CH_L;
                3'd3:    ch = CH_S;
                3'd4:    ch = CH_E;
                default: ch = CH_NUL;
            endcase
        end else begin
            case (pos)
                3'd0:    ch = CH_T;
                3'd1:    ch = CH_R;
                3'd2:    ch = CH_U;
                3'd3:    ch = CH_E;
                default: ch = CH_NUL;
            endcase
        end
        return ch;
    endfunction

    function automatic logic [7:0] null_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = CH_N;
            3'd1:    ch = CH_U;
            3'd2:    ch = CH_L;
            3'd3:    ch = CH_L;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/jbt_lexer.sv
module jbt_lexer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  jbt_pkg::t_item      i_item,
    output logic [1:0]          o_push_cnt,
    output jbt_pkg::t_result    o_res0,
    output jbt_pkg::t_result    o_res1,
    output jbt_pkg::t_lex_status o_status
);
    import jbt_pkg::*;

    t_lex_state r_state;
    t_lex_state n_state;
    t_lex_state id_state;
    logic       id_emit;
    t_result    id_res;
    t_result    fin_res;
    t_result    res0;
    t_result    res1;
    logic [1:0] cnt;

    logic [7:0] c;
    logic       eoi;
    logic       is_digit;
    logic [2:0] lit_len;
    logic [2:0] pos_inc;
    logic       bool_miss;
    logic       null_miss;
    logic       int_ok;
    logic [2:0] num_len;

    assign c         = i_item.data_byte;
    assign eoi       = i_item.end_of_input;
    assign is_digit  = c inside {[CH_ZERO:CH_NINE]};
    assign lit_len   = r_state.lit_false ? 3'd5 : 3'd4;
    assign pos_inc   = r_state.lit_pos + 3'd1;
    assign bool_miss = (r_state.lit_pos >= lit_len)
                       || (c != bool_char(r_state.lit_false, r_state.lit_pos));
    assign null_miss = (r_state.lit_pos >= 3'd4) || (c != null_char(r_state.lit_pos));

    // Number verdict when the token ends.
    assign int_ok  = (r_state.int_cnt == 2'd1) || !r_state.lead_zero;
    assign num_len = {1'b0, r_state.int_cnt} + 3'd1 + {1'b0, r_state.frac_len};

    always_comb begin
        if (r_state.dot_cnt == 2'd0 && int_ok) begin
            fin_res = mk_res(EV_DONE, KIND_INT, CH_NUL, ERR_NONE);
        end else if (r_state.dot_cnt == 2'd1 && int_ok && num_len >= 3'd3) begin
            fin_res = mk_res(EV_DONE, KIND_FLOAT, CH_NUL, ERR_NONE);
        end else begin
            fin_res = mk_res(EV_ERROR, KIND_INT, CH_NUL, ERR_NUMBER);
        end
    end

    // Handling of a byte seen in idle mode, also used for the byte that ends a number.
    always_comb begin
        id_state      = r_state;
        id_state.mode = MODE_IDLE;
        id_emit       = 1'b0;
        id_res        = mk_res(EV_DONE, KIND_LBRACK, c, ERR_NONE);
        case (c)
            CH_QUOTE: begin
                id_state.mode   = MODE_STRING;
                id_state.bs_odd = 1'b0;
            end
            CH_T, CH_F: begin
                id_state.mode      = MODE_BOOL;
                id_state.lit_pos   = 3'd1;
                id_state.lit_false = (c == CH_F);
                id_state.lit_mis   = 1'b0;
            end
            CH_N: begin
                id_state.mode    = MODE_NULL;
                id_state.lit_pos = 3'd1;
                id_state.lit_mis = 1'b0;
            end
            CH_MINUS: begin
                id_state.mode = MODE_MINUS;
            end
            CH_LBRACK: begin
                id_emit = 1'b1;
                id_res  = mk_res(EV_DONE, KIND_LBRACK, c, ERR_NONE);
            end
            CH_RBRACK: begin
                id_emit = 1'b1;
                id_res  = mk_res(EV_DONE, KIND_RBRACK, c, ERR_NONE);
            end
            CH_LBRACE: begin
                id_emit = 1'b1;
                id_res  = mk_res(EV_DONE, KIND_LBRACE, c, ERR_NONE);
            end
            CH_RBRACE: begin
                id_emit = 1'b1;
                id_res  = mk_res(EV_DONE, KIND_RBRACE, c, ERR_NONE);
            end
            CH_COLON: begin
                id_emit = 1'b1;
                id_res  = mk_res(EV_DONE, KIND_COLON, c, ERR_NONE);
            end
            CH_COMMA: begin
                id_emit = 1'b1;
                id_res  = mk_res(EV_DONE, KIND_COMMA, c, ERR_NONE);
            end
            default: begin
                if (is_digit) begin
                    id_state.mode      = MODE_NUMBER;
                    id_state.int_cnt   = 2'd1;
                    id_state.lead_zero = (c == CH_ZERO);
                    id_state.dot_cnt   = 2'd0;
                    id_state.frac_len  = 2'd0;
                    id_emit            = 1'b1;
                    id_res             = mk_res(EV_CONTENT, KIND_INT, c, ERR_NONE);
                end
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        if (eoi) begin
            n_state.mode = MODE_IDLE;
        end else begin
            case (r_state.mode)
                MODE_MINUS: begin
                    if (is_digit) begin
                        n_state.mode      = MODE_NUMBER;
                        n_state.int_cnt   = 2'd1;
                        n_state.lead_zero = (c == CH_ZERO);
                        n_state.dot_cnt   = 2'd0;
                        n_state.frac_len  = 2'd0;
                    end else begin
                        n_state.mode = MODE_IDLE;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit) begin
                        if (r_state.dot_cnt == 2'd0) begin
                            if (r_state.int_cnt < 2'd2) begin
                                n_state.int_cnt = r_state.int_cnt + 2'd1;
                            end
                        end else if (r_state.frac_len < 2'd2) begin
                            n_state.frac_len = r_state.frac_len + 2'd1;
                        end
                    end else if (c == CH_DOT) begin
                        if (r_state.dot_cnt < 2'd2) begin
                            n_state.dot_cnt = r_state.dot_cnt + 2'd1;
                        end
                    end else begin
                        n_state = id_state;
                    end
                end
                MODE_STRING: begin
                    if (c == CH_QUOTE && !r_state.bs_odd) begin
                        n_state.mode = MODE_IDLE;
                    end else begin
                        n_state.bs_odd = (c == CH_BSLASH) ? !r_state.bs_odd : 1'b0;
                    end
                end
                MODE_BOOL: begin
                    n_state.lit_mis = r_state.lit_mis | bool_miss;
                    n_state.lit_pos = pos_inc;
                    if (pos_inc >= lit_len) begin
                        n_state.mode = MODE_IDLE;
                    end
                end
                MODE_NULL: begin
                    n_state.lit_mis = r_state.lit_mis | null_miss;
                    n_state.lit_pos = pos_inc;
                    if (pos_inc >= 3'd4) begin
                        n_state.mode = MODE_IDLE;
                    end
                end
                default: begin
                    n_state = id_state;
                end
            endcase
        end
    end

    // Results of this word.
    always_comb begin
        cnt  = 2'd0;
        res0 = id_res;
        res1 = id_res;
        if (eoi) begin
            case (r_state.mode)
                MODE_MINUS: begin
                    cnt  = 2'd1;
                    res0 = mk_res(EV_ERROR, KIND_INT, CH_NUL, ERR_MINUS);
                end
                MODE_NUMBER: begin
                    cnt  = 2'd1;
                    res0 = fin_res;
                end
                MODE_STRING: begin
                    cnt  = 2'd1;
                    res0 = mk_res(EV_ERROR, KIND_STRING, CH_NUL, ERR_STRING);
                end
                MODE_BOOL: begin
                    cnt  = 2'd1;
                    res0 = mk_res(EV_ERROR, KIND_BOOL, CH_NUL, ERR_BOOL);
                end
                MODE_NULL: begin
                    cnt  = 2'd1;
                    res0 = mk_res(EV_ERROR, KIND_NULL, CH_NUL, ERR_NULL);
                end
                default: begin
                    cnt = 2'd0;
                end
            endcase
        end else begin
            case (r_state.mode)
                MODE_MINUS: begin
                    cnt = 2'd1;
                    if (is_digit) begin
                        cnt  = 2'd2;
                        res0 = mk_res(EV_CONTENT, KIND_INT, CH_MINUS, ERR_NONE);
                        res1 = mk_res(EV_CONTENT, KIND_INT, c, ERR_NONE);
                    end else begin
                        res0 = mk_res(EV_ERROR, KIND_INT, CH_NUL, ERR_MINUS);
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit || c == CH_DOT) begin
                        cnt  = 2'd1;
                        res0 = mk_res(EV_CONTENT, KIND_INT, c, ERR_NONE);
                    end else begin
                        cnt  = id_emit ? 2'd2 : 2'd1;
                        res0 = fin_res;
                        res1 = id_res;
                    end
                end
                MODE_STRING: begin
                    cnt = 2'd1;
                    if (c == CH_QUOTE && !r_state.bs_odd) begin
                        res0 = mk_res(EV_DONE, KIND_STRING, CH_NUL, ERR_NONE);
                    end else begin
                        res0 = mk_res(EV_CONTENT, KIND_STRING, c, ERR_NONE);
                    end
                end
                MODE_BOOL: begin
                    if (pos_inc >= lit_len) begin
                        cnt = 2'd1;
                        if (r_state.lit_mis || bool_miss) begin
                            res0 = mk_res(EV_ERROR, KIND_BOOL, CH_NUL, ERR_BOOL);
                        end else begin
                            res0 = mk_res(EV_DONE, KIND_BOOL,
                                          {7'd0, !r_state.lit_false}, ERR_NONE);
                        end
                    end
                end
                MODE_NULL: begin
                    if (pos_inc >= 3'd4) begin
                        cnt = 2'd1;
                        if (r_state.lit_mis || null_miss) begin
                            res0 = mk_res(EV_ERROR, KIND_NULL, CH_NUL, ERR_NULL);
                        end else begin
                            res0 = mk_res(EV_DONE, KIND_NULL, CH_NUL, ERR_NONE);
                        end
                    end
                end
                default: begin
                    cnt  = id_emit ? 2'd1 : 2'd0;
                    res0 = id_res;
                end
            endcase
        end
        // The final result of the word carries the last flag.
        if (cnt == 2'd1) begin
            res0.last = 1'b1;
        end
        if (cnt == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{MODE_IDLE, 1'b0, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0, 2'd0, 2'd0};
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

    assign o_push_cnt  = cnt;
    assign o_res0      = res0;
    assign o_res1      = res1;
    assign o_status.idle = (r_state.mode == MODE_IDLE);

endmodule

// File: rtl/jbt_out_queue.sv
module jbt_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_cnt,
    input  jbt_pkg::t_result i_res0,
    input  jbt_pkg::t_result i_res1,
    input  logic             i_pop,
    output jbt_pkg::t_result o_head,
    output jbt_pkg::t_q_status o_status
);
    import jbt_pkg::*;

    // Shifting queue: entry zero is always the head.
    t_result [Q_DEPTH-1:0] r_q;
    t_result [Q_DEPTH-1:0] n_q;
    logic [Q_CNT_W-1:0]    r_count;
    logic [Q_CNT_W-1:0]    n_count;
    logic [Q_CNT_W-1:0]    base;
    logic [Q_IDX_W-1:0]    base_next;

    always_comb begin
        n_q = r_q;
        if (i_pop) begin
            for (int i = 0; i < Q_DEPTH - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
        end
        base      = r_count - Q_CNT_W'(i_pop);
        base_next = base[Q_IDX_W-1:0] + Q_IDX_W'(1);
        if (i_push_cnt != 2'd0) begin
            n_q[base[Q_IDX_W-1:0]] = i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            n_q[base_next] = i_res1;
        end
        n_count = base + Q_CNT_W'(i_push_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_head         = r_q[0];
    assign o_status.count = r_count;
    assign o_status.room  = (r_count <= Q_CNT_W'(Q_DEPTH - 2));

endmodule

// File: rtl/json_byte_tokenizer.sv
// Streaming JSON tokenizer, one character byte per input word.
// Input channel: i_in_valid / o_in_stall carry i_in_word, holding a data byte and an
// end-of-input flag. A word is taken at a rising edge where valid is high and stall low.
// Output channel: o_out_valid / i_out_stall carry o_out_word, one result per word:
// content bytes, token completions and errors, with the last flag on the final result
// that a given input word causes. An input word gives zero, one or two results.
// Latency: the results of a word are written into the result queue at the edge that
// accepts it; the first is offered in the following cycle if the queue held none before.
// Throughput: one input word per cycle while each word gives at most one result and the
// receiver does not stall; a word that gives two results needs the single output port
// for both, so the output port sets the sustained rate at one result per cycle.
// Stalling: a four-entry result queue parts the two sides. Input is taken while the
// queue has room for two more results, so every result of a taken word fits at once.
// Reset: synchronous and active low; the lexer returns to idle and the queue empties.
module json_byte_tokenizer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  jbt_pkg::t_item   i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output jbt_pkg::t_result o_out_word
);
    import jbt_pkg::*;

    logic        accept;
    logic        pop;
    logic [1:0]  lex_cnt;
    logic [1:0]  push_cnt;
    t_result     lex_res0;
    t_result     lex_res1;
    t_lex_status lex_status;
    t_q_status   q_status;

    // Stall depends only on the queue fill, never on the input valid.
    assign o_in_stall  = !q_status.room;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = (q_status.count != '0);
    assign pop         = o_out_valid && !i_out_stall;
    assign push_cnt    = accept ? lex_cnt : 2'd0;

    jbt_lexer u_lexer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in_word),
        .o_push_cnt (lex_cnt),
        .o_res0     (lex_res0),
        .o_res1     (lex_res1),
        .o_status   (lex_status)
    );

    jbt_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (lex_res0),
        .i_res1     (lex_res1),
        .i_pop      (pop),
        .o_head     (o_out_word),
        .o_status   (q_status)
    );

    // The queue never holds more than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overfilled");

    // Fill count follows pushes and pops exactly.
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> q_status.count == Q_CNT_W'($past(q_status.count)
            + Q_CNT_W'($past(push_cnt)) - Q_CNT_W'($past(pop))))
        else $error("result queue count lost track");

    // End of input always leaves the lexer idle.
    a_eoi_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_word.end_of_input |=> lex_status.idle)
        else $error("lexer not idle after end of input");

    // A word that gives two results marks only the second as last.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_cnt == 2'd2 |-> !lex_res0.last && lex_res1.last)
        else $error("last flag misplaced");

endmodule
